### src/rsc_pkg.sv
// ----------------------------------------------------------------------------
// rsc_pkg
// Shared types, widths and character codes of the radix string converter.
// ----------------------------------------------------------------------------
package rsc_pkg;

  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned MAX_DIGITS  = 32;

  localparam int unsigned CharW   = 8;
  localparam int unsigned BaseW   = 5;
  localparam int unsigned DigitW  = 4;
  localparam int unsigned StatusW = 3;
  localparam int unsigned CfgIdxW = 4;
  localparam int unsigned ProdW   = VALUE_WIDTH + BaseW;
  localparam int unsigned StepW   = $clog2(VALUE_WIDTH);
  localparam int unsigned IdxW    = $clog2(MAX_DIGITS);
  localparam int unsigned CntW    = $clog2(MAX_DIGITS + 1);

  localparam logic [BaseW-1:0] BaseMin      = BaseW'(2);
  localparam logic [BaseW-1:0] BaseMax      = BaseW'(16);
  localparam logic [BaseW-1:0] SrcBaseReset = BaseW'(10);
  localparam logic [BaseW-1:0] TgtBaseReset = BaseW'(2);

  localparam logic [CharW-1:0] CharZero  = 8'h30;  // '0'
  localparam logic [CharW-1:0] CharNine  = 8'h39;  // '9'
  localparam logic [CharW-1:0] CharUpA   = 8'h41;  // 'A'
  localparam logic [CharW-1:0] CharUpF   = 8'h46;  // 'F'
  localparam logic [CharW-1:0] CharPoint = 8'h2E;  // '.'
  localparam logic [CharW-1:0] CharMinus = 8'h2D;  // '-'
  // 'A' - 10, so that a digit of ten or more maps straight onto a letter
  localparam logic [CharW-1:0] CharLetterBase = 8'h37;

  localparam logic [CfgIdxW-1:0] CFG_SOURCE_BASE = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CFG_TARGET_BASE = CfgIdxW'(1);

  typedef enum logic [StatusW-1:0] {
    ST_OK          = 3'd0,
    ST_BAD_DIGIT   = 3'd1,
    ST_NEGATIVE    = 3'd2,
    ST_MULTI_POINT = 3'd3,
    ST_FRACTION    = 3'd4,
    ST_SAME_BASE   = 3'd5,
    ST_OVERFLOW    = 3'd6
  } status_e;

  typedef struct packed {
    logic                   start;
    logic [VALUE_WIDTH-1:0] dividend;
    logic [BaseW-1:0]       divisor;
  } div_ctrl_t;

  typedef struct packed {
    logic                   done;
    logic [VALUE_WIDTH-1:0] quotient;
    logic [DigitW-1:0]      remainder;
  } div_stat_t;

  function automatic logic [BaseW-1:0] clamp_base(logic [BaseW-1:0] b);
    logic [BaseW-1:0] r;
    r = b;
    if (b < BaseMin) r = BaseMin;
    else if (b > BaseMax) r = BaseMax;
    return r;
  endfunction

  function automatic logic [CharW-1:0] digit_to_char(logic [DigitW-1:0] d);
    logic [CharW-1:0] r;
    if (d < DigitW'(10)) r = CharZero + CharW'(d);
    else r = CharLetterBase + CharW'(d);
    return r;
  endfunction

endpackage

### src/rsc_if.sv
// ----------------------------------------------------------------------------
// rsc_if
// Handshake channels of the radix string converter: characters in, result
// digits out, and the register write port.
// ----------------------------------------------------------------------------
interface rsc_in_if;
  logic                       valid;
  logic                       ready;
  logic [rsc_pkg::CharW-1:0]  char_code;
  logic                       is_last;

  modport source (output valid, output char_code, output is_last, input ready);
  modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

interface rsc_out_if;
  logic                        valid;
  logic                        ready;
  logic [rsc_pkg::CharW-1:0]   digit_char;
  logic [rsc_pkg::StatusW-1:0] status;
  logic                        last_out;

  modport source (output valid, output digit_char, output status, output last_out,
                  input ready);
  modport sink   (input valid, input digit_char, input status, input last_out,
                  output ready);
endinterface

interface rsc_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [rsc_pkg::CfgIdxW-1:0] index;
  logic [rsc_pkg::BaseW-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### src/radix_string_converter_top.sv
// ----------------------------------------------------------------------------
// radix_string_converter_top
// Converts an ASCII numeral in one radix into ASCII digits of another.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_i : register writes, index 0 source base, index 1 target base; always
//           ready. Write only while the block is idle.
//   in_i  : one character word per handshake, most significant first, is_last
//           on the final one. A character that is not last is absorbed (one
//           multiply-add on the accumulator) and gives no result.
//   out_o : result words, most significant digit first, last_out on the final
//           one; or a single error word with digit_char zero.
// For a last character, an error word is registered from the finish state
// once the output register is free; otherwise the finish state starts the
// bit-serial divider (one quotient bit a cycle), run once per target digit,
// then digits leave at one a cycle while the receiver is ready. The input is
// not ready from a last character until the final result word is registered.
// Results sit in an output register; a stalled receiver holds that word and,
// once the final word is registered, the next numeral may already be taken.
// Reset clears the numeral state and loads base ten in and base two out.
// ----------------------------------------------------------------------------
module radix_string_converter_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  rsc_cfg_if.sink    cfg_i,
  rsc_in_if.sink     in_i,
  rsc_out_if.source  out_o
);
  import rsc_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_FINISH = 2'd1;
  localparam logic [1:0] S_DIV    = 2'd2;
  localparam logic [1:0] S_EMIT   = 2'd3;

  logic [1:0]             state_q, state_d;
  logic [BaseW-1:0]       src_base_q, tgt_base_q;
  logic [VALUE_WIDTH-1:0] acc_q, acc_d;
  status_e                err_q, err_d;
  logic [1:0]             pts_q, pts_d;
  status_e                code_q, code_d;
  logic [VALUE_WIDTH-1:0] conv_q, conv_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic [DigitW-1:0]      digit_buf_q [MAX_DIGITS];
  logic                   buf_we;
  logic                   emit_rd;

  logic                   out_valid_q, out_valid_d;
  logic [CharW-1:0]       out_char_q, out_char_d;
  status_e                out_status_q, out_status_d;
  logic                   out_last_q, out_last_d;
  logic                   out_free;

  logic [BaseW-1:0]       sb, tb;
  logic                   accept;
  logic [CharW-1:0]       c;
  logic                   is_dec, is_hex;
  logic [DigitW-1:0]      dval;
  logic [ProdW-1:0]       prod;
  status_e                take_err;
  logic [1:0]             take_pts;
  logic [VALUE_WIDTH-1:0] take_acc;
  status_e                final_code;
  logic [IdxW-1:0]        rd_idx;

  div_ctrl_t              div_ctrl;
  div_stat_t              div_stat;

  rsc_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (div_ctrl),
    .stat_o (div_stat)
  );

  assign sb = clamp_base(src_base_q);
  assign tb = clamp_base(tgt_base_q);

  assign in_i.ready  = (state_q == S_IDLE);
  assign accept      = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;
  assign out_free    = !out_valid_q || out_o.ready;

  // Character decode and accumulate
  assign c      = in_i.char_code;
  assign is_dec = (c >= CharZero) && (c <= CharNine);
  assign is_hex = (c >= CharUpA) && (c <= CharUpF);
  assign dval   = is_dec ? DigitW'(c - CharZero) : DigitW'(c - CharLetterBase);
  assign prod   = ProdW'(acc_q) * ProdW'(sb) + ProdW'(dval);

  always_comb begin
    take_err = err_q;
    take_pts = pts_q;
    take_acc = acc_q;
    if (c == CharPoint) begin
      if (pts_q != 2'd2) take_pts = pts_q + 2'd1;
    end else if (c == CharMinus) begin
      if (err_q == ST_OK || err_q == ST_OVERFLOW) take_err = ST_NEGATIVE;
    end else if (!(is_dec || is_hex) || (BaseW'(dval) >= sb)) begin
      if (err_q == ST_OK || err_q == ST_OVERFLOW) take_err = ST_BAD_DIGIT;
    end else if (err_q == ST_OK) begin
      // stop accumulating once the value no longer fits
      if (prod[ProdW-1:VALUE_WIDTH] != '0) take_err = ST_OVERFLOW;
      else take_acc = prod[VALUE_WIDTH-1:0];
    end
  end

  always_comb begin
    if (sb == tb) final_code = ST_SAME_BASE;
    else if (take_err == ST_BAD_DIGIT || take_err == ST_NEGATIVE) final_code = take_err;
    else if (take_pts == 2'd2) final_code = ST_MULTI_POINT;
    else if (take_pts == 2'd1) final_code = ST_FRACTION;
    else final_code = take_err;
  end

  assign rd_idx = IdxW'(cnt_q - CntW'(1));

  // Sequencer
  always_comb begin
    state_d      = state_q;
    acc_d        = acc_q;
    err_d        = err_q;
    pts_d        = pts_q;
    code_d       = code_q;
    conv_d       = conv_q;
    cnt_d        = cnt_q;
    buf_we       = 1'b0;
    emit_rd      = 1'b0;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_char_d   = out_char_q;
    out_status_d = out_status_q;
    out_last_d   = out_last_q;
    div_ctrl.start    = 1'b0;
    div_ctrl.dividend = (state_q == S_FINISH) ? conv_q : div_stat.quotient;
    div_ctrl.divisor  = tb;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (in_i.is_last) begin
            acc_d   = '0;
            err_d   = ST_OK;
            pts_d   = '0;
            code_d  = final_code;
            conv_d  = take_acc;
            state_d = S_FINISH;
          end else begin
            acc_d = take_acc;
            err_d = take_err;
            pts_d = take_pts;
          end
        end
      end
      S_FINISH: begin
        if (code_q != ST_OK) begin
          if (out_free) begin
            out_valid_d  = 1'b1;
            out_char_d   = '0;
            out_status_d = code_q;
            out_last_d   = 1'b1;
            state_d      = S_IDLE;
          end
        end else begin
          div_ctrl.start = 1'b1;
          cnt_d          = '0;
          state_d        = S_DIV;
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          buf_we = 1'b1;
          cnt_d  = cnt_q + CntW'(1);
          if (div_stat.quotient == '0) begin
            state_d = S_EMIT;
          end else if (cnt_q + CntW'(1) >= CntW'(MAX_DIGITS)) begin
            code_d  = ST_OVERFLOW;
            state_d = S_FINISH;
          end else begin
            div_ctrl.start = 1'b1;
          end
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          emit_rd      = 1'b1;
          out_status_d = ST_OK;
          out_last_d   = (cnt_q == CntW'(1));
          cnt_d        = cnt_q - CntW'(1);
          if (cnt_q == CntW'(1)) state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      src_base_q  <= SrcBaseReset;
      tgt_base_q  <= TgtBaseReset;
      acc_q       <= '0;
      err_q       <= ST_OK;
      pts_q       <= '0;
      code_q      <= ST_OK;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      acc_q       <= acc_d;
      err_q       <= err_d;
      pts_q       <= pts_d;
      code_q      <= code_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.valid && cfg_i.ready) begin
        if (cfg_i.index == CFG_SOURCE_BASE) src_base_q <= cfg_i.data;
        else if (cfg_i.index == CFG_TARGET_BASE) tgt_base_q <= cfg_i.data;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    conv_q       <= conv_d;
    out_status_q <= out_status_d;
    out_last_q   <= out_last_d;
    if (emit_rd) out_char_q <= digit_to_char(digit_buf_q[rd_idx]);
    else out_char_q <= out_char_d;
    if (buf_we) digit_buf_q[cnt_q[IdxW-1:0]] <= div_stat.remainder;
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.digit_char = out_char_q;
  assign out_o.status     = out_status_q;
  assign out_o.last_out   = out_last_q;

endmodule

### src/rsc_divider.sv
// ----------------------------------------------------------------------------
// rsc_divider
// Bit-serial restoring divider: one quotient bit per cycle, giving the
// quotient and the remainder (one target digit) of a value by a small base.
// ----------------------------------------------------------------------------
module rsc_divider (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rsc_pkg::div_ctrl_t ctrl_i,
  output rsc_pkg::div_stat_t stat_o
);
  import rsc_pkg::*;

  logic                   busy_q, busy_d;
  logic                   done_q, done_d;
  logic [StepW-1:0]       cnt_q, cnt_d;
  logic [VALUE_WIDTH-1:0] quo_q, quo_d;
  logic [DigitW-1:0]      rem_q, rem_d;
  logic [BaseW-1:0]       dsr_q, dsr_d;
  logic [BaseW-1:0]       trial;
  logic                   fits;

  // partial remainder shifted left by one, next dividend bit brought in
  assign trial = {rem_q, quo_q[VALUE_WIDTH-1]};
  assign fits  = (trial >= dsr_q);

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (ctrl_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = ctrl_i.dividend;
      rem_d  = '0;
      dsr_d  = ctrl_i.divisor;
    end else if (busy_q) begin
      quo_d = {quo_q[VALUE_WIDTH-2:0], fits};
      rem_d = fits ? DigitW'(trial - dsr_q) : DigitW'(trial);
      cnt_d = cnt_q + StepW'(1);
      if (cnt_q == StepW'(VALUE_WIDTH - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign stat_o.done      = done_q;
  assign stat_o.quotient  = quo_q;
  assign stat_o.remainder = rem_q;

endmodule

### tb/tb_radix_string_converter_top.sv
// ----------------------------------------------------------------------------
// tb_radix_string_converter_top
// Self-checking bench for the radix string converter. Numerals go in one
// character word at a time under many base pairs, and an in-bench model of the
// conversion predicts every result word. Each word leaving the block is
// checked against the oldest prediction. Both handshake sides idle at random but in one no-idle phase.
// ----------------------------------------------------------------------------
module tb_radix_string_converter_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rsc_pkg::*;

  typedef struct packed {
    logic [CharW-1:0] digit_char;
    status_e          status;
    logic             last_out;
  } result_word_t;

  logic clk_i;
  logic rst_ni;

  rsc_cfg_if cfg_if ();
  rsc_in_if  in_if ();
  rsc_out_if out_if ();

  radix_string_converter_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Model state: registers as written and the numeral being built
  logic [BaseW-1:0]   src_reg;
  logic [BaseW-1:0]   tgt_reg;
  longint unsigned    acc_value;
  status_e            pending_err;
  int unsigned        point_seen;

  result_word_t       words_due[$];

  bit                 idle_off;
  int unsigned        mismatches;
  int unsigned        words_checked;
  int unsigned        chars_sent;
  int unsigned        numerals_sent;
  int unsigned        reg_writes;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #15_000_000;
    $display("Timed out with %0d result words still due", words_due.size());
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic int unsigned radix_of(logic [BaseW-1:0] b);
    if (b < 2) return 2;
    if (b > 16) return 16;
    return 32'(b);
  endfunction

  function automatic logic [CharW-1:0] numeral_char(int unsigned d);
    if (d < 10) return CharZero + CharW'(d);
    return CharUpA + CharW'(d - 10);
  endfunction

  function automatic void clear_numeral();
    acc_value   = 0;
    pending_err = ST_OK;
    point_seen  = 0;
  endfunction

  function automatic void push_error_word(status_e code);
    result_word_t w;
    w.digit_char = '0;
    w.status     = code;
    w.last_out   = 1'b1;
    words_due.push_back(w);
  endfunction

  // Fold one accepted character into the numeral; on the last one queue the
  // result words it must produce.
  function automatic void convert_char(logic [CharW-1:0] c, logic last);
    int unsigned     sb;
    int unsigned     tb;
    int unsigned     d;
    int unsigned     n;
    longint unsigned mask;
    longint unsigned v;
    logic [3:0]      digs[MAX_DIGITS];
    status_e         code;
    result_word_t    w;

    sb   = radix_of(src_reg);
    tb   = radix_of(tgt_reg);
    mask = (64'd1 << VALUE_WIDTH) - 1;

    if (c == CharPoint) begin
      if (point_seen < 2) point_seen++;
    end else if (c == CharMinus) begin
      if (pending_err == ST_OK || pending_err == ST_OVERFLOW) pending_err = ST_NEGATIVE;
    end else begin
      if (c >= CharZero && c <= CharNine) d = 32'(c - CharZero);
      else if (c >= CharUpA && c <= CharUpF) d = 32'(c - CharUpA) + 10;
      else d = 16;
      if (d >= sb) begin
        if (pending_err == ST_OK || pending_err == ST_OVERFLOW) pending_err = ST_BAD_DIGIT;
      end else if (pending_err == ST_OK) begin
        // stop accumulating once the value no longer fits
        if (acc_value * sb + d > mask) pending_err = ST_OVERFLOW;
        else acc_value = acc_value * sb + d;
      end
    end

    if (!last) return;
    numerals_sent++;

    if (sb == tb) code = ST_SAME_BASE;
    else if (pending_err == ST_BAD_DIGIT || pending_err == ST_NEGATIVE) code = pending_err;
    else if (point_seen >= 2) code = ST_MULTI_POINT;
    else if (point_seen == 1) code = ST_FRACTION;
    else code = pending_err;

    if (code != ST_OK) begin
      push_error_word(code);
      clear_numeral();
      return;
    end

    v = acc_value;
    n = 0;
    do begin
      digs[n] = 4'(v % tb);
      v = v / tb;
      n++;
    end while (v != 0 && n < MAX_DIGITS);

    if (v != 0) begin
      push_error_word(ST_OVERFLOW);
    end else begin
      for (int k = 0; k < n; k++) begin
        w.digit_char = numeral_char(digs[n - 1 - k]);
        w.status     = ST_OK;
        w.last_out   = (k == n - 1);
        words_due.push_back(w);
      end
    end
    clear_numeral();
  endfunction

  // Result side: stall at random, then hold ready until a word is taken
  initial begin
    int unsigned stall;
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      stall = idle_off ? 0 : $urandom_range(0, 13);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
    end
  end

  always @(posedge clk_i) begin
    result_word_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      words_checked++;
      if (words_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected word digit=%h status=%0d last=%b", $realtime,
                   out_if.digit_char, out_if.status, out_if.last_out);
      end else begin
        want = words_due.pop_front();
        if (out_if.digit_char !== want.digit_char || out_if.status !== want.status ||
            out_if.last_out !== want.last_out) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: word mismatch: expected %h/%0d/%b, got %h/%0d/%b",
                     $realtime, want.digit_char, want.status, want.last_out,
                     out_if.digit_char, out_if.status, out_if.last_out);
        end
      end
    end
  end

  task automatic send_char(logic [CharW-1:0] c, logic last);
    int unsigned gap;
    gap = idle_off ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.char_code <= c;
    in_if.is_last   <= last;
    do @(posedge clk_i); while (!in_if.ready);
    chars_sent++;
    convert_char(c, last);
  endtask

  task automatic send_string(string s);
    for (int k = 0; k < s.len(); k++) send_char(s[k], k == s.len() - 1);
  endtask

  // Drop valid and hold off until every predicted word has come and the
  // divider has had time to fall quiet.
  task automatic settle();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (words_due.size() != 0) @(posedge clk_i);
    repeat (VALUE_WIDTH + 8) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [BaseW-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    if (idx == CFG_SOURCE_BASE) src_reg = value;
    else tgt_reg = value;
    reg_writes++;
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_bases(logic [BaseW-1:0] src, logic [BaseW-1:0] tgt);
    settle();
    write_reg(CFG_SOURCE_BASE, src);
    write_reg(CFG_TARGET_BASE, tgt);
  endtask

  function automatic logic [BaseW-1:0] pick_base();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return BaseW'($urandom_range(0, 1));
    if (r == 1) return BaseW'($urandom_range(17, 31));
    return BaseW'($urandom_range(2, 16));
  endfunction

  // Mostly clean numerals; some carry a point, a minus sign or a stray
  // character, some are long enough to overflow, and a few are pure noise.
  task automatic send_random_numeral();
    int unsigned      sb;
    int unsigned      kind;
    int unsigned      len;
    int unsigned      pos;
    logic [CharW-1:0] c;
    sb   = radix_of(src_reg);
    kind = $urandom_range(0, 99);
    if (kind < 10) begin
      len = $urandom_range(1, 4);
      for (int k = 0; k < len; k++) send_char(CharW'($urandom_range(0, 255)), k == len - 1);
    end else begin
      len = (kind < 18) ? $urandom_range(20, 34) : $urandom_range(1, 10);
      pos = $urandom_range(0, len - 1);
      for (int k = 0; k < len; k++) begin
        c = numeral_char($urandom_range(0, sb - 1));
        if (kind >= 18 && kind < 26 && k == pos) c = CharPoint;
        if (kind >= 26 && kind < 30 && (k == pos || k == (pos + 1) % len)) c = CharPoint;
        if (kind >= 30 && kind < 34 && k == pos) c = CharMinus;
        if (kind >= 34 && kind < 40 && k == pos) c = CharW'($urandom_range(0, 255));
        send_char(c, k == len - 1);
      end
    end
  endtask

  task automatic test_default_bases();
    send_string("0");
    send_string("-5");
    send_string("a");
    send_string("..");
    send_string(".");
    send_string("A");
  endtask

  task automatic test_same_base();
    set_bases(BaseW'(16), BaseW'(16));
    send_string("1");
  endtask

  task automatic test_widest_output();
    // both registers out of range: source reads as sixteen, target as two
    set_bases(BaseW'(31), BaseW'(0));
    send_string("FFFFFFFF");
  endtask

  task automatic test_accumulator_overflow();
    set_bases(BaseW'(16), BaseW'(10));
    send_string("100000000");
  endtask

  task automatic test_random_numerals(int unsigned phases, int unsigned chars_per_phase);
    int unsigned start;
    for (int p = 0; p < phases; p++) begin
      if (p == 0) set_bases(BaseW'(2), BaseW'(16));
      else set_bases(pick_base(), pick_base());
      start = chars_sent;
      while (chars_sent - start < chars_per_phase) send_random_numeral();
    end
  endtask

  task automatic test_no_idle(int unsigned chars_per_phase);
    int unsigned start;
    set_bases(BaseW'(10), BaseW'(16));
    idle_off = 1'b1;
    start    = chars_sent;
    while (chars_sent - start < chars_per_phase) send_random_numeral();
    settle();
    idle_off = 1'b0;
  endtask

  initial begin
    rst_ni          <= 1'b0;
    in_if.valid     <= 1'b0;
    in_if.char_code <= '0;
    in_if.is_last   <= 1'b0;
    cfg_if.valid    <= 1'b0;
    cfg_if.index    <= '0;
    cfg_if.data     <= '0;
    idle_off      = 1'b0;
    mismatches    = 0;
    words_checked = 0;
    chars_sent    = 0;
    numerals_sent = 0;
    reg_writes    = 0;
    src_reg       = BaseW'(10);
    tgt_reg       = BaseW'(2);
    clear_numeral();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_default_bases();
    test_same_base();
    test_widest_output();
    test_accumulator_overflow();
    test_random_numerals(6, 66);
    test_no_idle(66);
    settle();

    $display("Sent %0d characters in %0d numerals over %0d register writes;", chars_sent,
             numerals_sent, reg_writes);
    $display("checked %0d result words, %0d mismatches.", words_checked, mismatches);
    if (mismatches == 0 && words_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### files.f
src/rsc_pkg.sv
src/rsc_if.sv
src/rsc_divider.sv
src/radix_string_converter_top.sv
tb/tb_radix_string_converter_top.sv
